FILE: rtl/core/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// shared types and constants for the graph depth-first search block
// ----------------------------------------------------------------------------
package gdfs_pkg;

    localparam int MAX_NODES        = 64;
    localparam int MAX_LIST_ENTRIES = 256;
    localparam int NODE_W           = $clog2(MAX_NODES);
    localparam int ENTRY_W          = $clog2(MAX_LIST_ENTRIES);
    localparam int PTR_W            = ENTRY_W + 1;
    localparam int DEPTH_W          = NODE_W + 1;
    localparam logic [PTR_W-1:0] NIL_ENTRY = PTR_W'(MAX_LIST_ENTRIES);

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] end_a;
        logic [6:0] end_b;
    } item_t;

    typedef struct packed {
        logic [6:0] visited_node;
        logic       last;
        logic       edges_dropped;
    } result_t;

endpackage

FILE: rtl/core/graph_depth_first_search.sv
// ----------------------------------------------------------------------------
// graph_depth_first_search
// undirected graph loader with depth-first traversal from node 1
// ----------------------------------------------------------------------------
// An edge request holds the input from acceptance until two list appends, each
// a tail read, an entry write and a link write into the entry memories, are
// done. A dropped edge only sets the sticky dropped flag. A run reads the list
// head of the start node and of each node pushed in S_HEAD, walks adjacency
// entries through S_STEP and S_EDGE, pops frames through S_STEP and S_POP and
// ends in S_DONE, waiting in S_EDGE and S_DONE while the result register is
// full and result_ready is low. Memory reads are registered. Results leave
// through one output register, and the final node of a run carries last.
// There is no clearing pass: list heads have per-node valid bits cleared by
// reset, and the visited marks are a register vector cleared when a run starts.
module graph_depth_first_search (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  gdfs_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output gdfs_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata
);
    import gdfs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_E_RD = 4'd1;
    localparam logic [3:0] S_E_WR = 4'd2;
    localparam logic [3:0] S_E_LK = 4'd3;
    localparam logic [3:0] S_HEAD = 4'd4;
    localparam logic [3:0] S_STEP = 4'd5;
    localparam logic [3:0] S_EDGE = 4'd6;
    localparam logic [3:0] S_POP  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [PTR_W-1:0]  cursor;
    } frame_t;

    logic [ENTRY_W-1:0] entry_target_mem [MAX_LIST_ENTRIES];
    logic [PTR_W-1:0]   entry_next_mem   [MAX_LIST_ENTRIES];
    logic [ENTRY_W-1:0] head_mem         [MAX_NODES];
    logic [ENTRY_W-1:0] tail_mem         [MAX_NODES];
    frame_t             stack_mem        [MAX_NODES];

    logic [3:0]         state_reg;
    logic [6:0]         node_count_reg;
    logic [PTR_W-1:0]   entry_count_reg;
    logic               dropped_reg;
    logic [MAX_NODES-1:0] list_valid_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [NODE_W-1:0]  node_a_reg, node_b_reg;
    logic               side_reg;
    logic [ENTRY_W-1:0] old_tail_reg;
    logic               old_valid_reg;
    logic [NODE_W-1:0]  top_node_reg;
    logic [PTR_W-1:0]   top_cur_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [6:0]         pend_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic [ENTRY_W-1:0] target_q;
    logic [PTR_W-1:0]   next_q;
    logic [ENTRY_W-1:0] head_q, tail_q;
    frame_t             stack_q;

    logic [6:0]         n_eff;
    logic [NODE_W-1:0]  from_node, to_node;
    logic [NODE_W-1:0]  t_node;
    logic [NODE_W-1:0]  head_raddr;
    logic [NODE_W-1:0]  stack_raddr;
    logic [NODE_W-1:0]  stack_waddr;
    logic [ENTRY_W-1:0] cur_entry;
    logic               out_free;
    logic               edge_bad;
    logic               t_skip;
    logic               emit;

    assign n_eff = (node_count_reg == 7'd0) ? 7'd1 :
                   (node_count_reg > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count_reg;

    assign edge_bad = (item.end_a == 7'd0) || (item.end_b == 7'd0) ||
                      (item.end_a > n_eff) || (item.end_b > n_eff) ||
                      ({1'b0, entry_count_reg} + (PTR_W+1)'(2) >
                       (PTR_W+1)'(MAX_LIST_ENTRIES));

    assign from_node   = side_reg ? node_b_reg : node_a_reg;
    assign to_node     = side_reg ? node_a_reg : node_b_reg;
    assign t_node      = target_q[NODE_W-1:0];
    assign t_skip      = ({1'b0, t_node} >= n_eff) || visited_reg[t_node];
    assign head_raddr  = (state_reg == S_IDLE) ? '0 : t_node;
    assign stack_raddr = NODE_W'(depth_reg - DEPTH_W'(2));
    assign stack_waddr = NODE_W'(depth_reg - DEPTH_W'(1));
    assign cur_entry   = top_cur_reg[ENTRY_W-1:0];
    assign out_free    = !result_valid_reg || result_ready;
    // a result is loaded on a new visit or at the end of a run
    assign emit        = out_free && (((state_reg == S_EDGE) && !t_skip) ||
                                      (state_reg == S_DONE));

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // memory read ports, registered
    always_ff @(posedge clk)
    begin
        target_q <= entry_target_mem[cur_entry];
        next_q   <= entry_next_mem[cur_entry];
        head_q   <= head_mem[head_raddr];
        tail_q   <= tail_mem[from_node];
        stack_q  <= stack_mem[stack_raddr];
    end

    // memory write ports
    always_ff @(posedge clk)
    begin
        if (state_reg == S_E_WR)
        begin
            entry_target_mem[entry_count_reg[ENTRY_W-1:0]] <= ENTRY_W'(to_node);
            entry_next_mem[entry_count_reg[ENTRY_W-1:0]]   <= NIL_ENTRY;
            tail_mem[from_node] <= entry_count_reg[ENTRY_W-1:0];
            if (!list_valid_reg[from_node])
            begin
                head_mem[from_node] <= entry_count_reg[ENTRY_W-1:0];
            end
        end
        if (state_reg == S_E_LK && old_valid_reg)
        begin
            entry_next_mem[old_tail_reg] <= entry_count_reg;
        end
        if (state_reg == S_EDGE && !t_skip && out_free &&
            depth_reg < DEPTH_W'(MAX_NODES))
        begin
            stack_mem[stack_waddr] <= '{node: top_node_reg, cursor: next_q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            node_count_reg   <= 7'(MAX_NODES);
            entry_count_reg  <= '0;
            dropped_reg      <= 1'b0;
            list_valid_reg   <= '0;
            visited_reg      <= '0;
            side_reg         <= 1'b0;
            old_valid_reg    <= 1'b0;
            depth_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.kind == KIND_RUN)
                        begin
                            visited_reg    <= MAX_NODES'(1);
                            pend_reg       <= 7'd1;
                            top_node_reg   <= '0;
                            depth_reg      <= DEPTH_W'(1);
                            state_reg      <= S_HEAD;
                        end
                        else if (edge_bad)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            node_a_reg <= NODE_W'(item.end_a - 7'd1);
                            node_b_reg <= NODE_W'(item.end_b - 7'd1);
                            side_reg   <= 1'b0;
                            state_reg  <= S_E_RD;
                        end
                    end
                end
                S_E_RD:
                begin
                    state_reg <= S_E_WR;
                end
                S_E_WR:
                begin
                    old_tail_reg              <= tail_q;
                    old_valid_reg             <= list_valid_reg[from_node];
                    list_valid_reg[from_node] <= 1'b1;
                    state_reg                 <= S_E_LK;
                end
                S_E_LK:
                begin
                    entry_count_reg <= entry_count_reg + PTR_W'(1);
                    side_reg        <= 1'b1;
                    state_reg       <= side_reg ? S_IDLE : S_E_RD;
                end
                S_HEAD:
                begin
                    top_cur_reg <= list_valid_reg[top_node_reg] ? {1'b0, head_q} : NIL_ENTRY;
                    state_reg   <= S_STEP;
                end
                S_STEP:
                begin
                    if (top_cur_reg[PTR_W-1])
                    begin
                        state_reg <= (depth_reg == DEPTH_W'(1)) ? S_DONE : S_POP;
                    end
                    else
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    if (t_skip)
                    begin
                        top_cur_reg <= next_q;
                        state_reg   <= S_STEP;
                    end
                    else if (out_free)
                    begin
                        visited_reg[t_node] <= 1'b1;
                        result_reg          <= '{visited_node: pend_reg, last: 1'b0,
                                                 edges_dropped: dropped_reg};
                        pend_reg            <= 7'(t_node) + 7'd1;
                        if (depth_reg < DEPTH_W'(MAX_NODES))
                        begin
                            top_node_reg <= t_node;
                            depth_reg    <= depth_reg + DEPTH_W'(1);
                            state_reg    <= S_HEAD;
                        end
                        else
                        begin
                            top_cur_reg <= next_q;
                            state_reg   <= S_STEP;
                        end
                    end
                end
                S_POP:
                begin
                    top_node_reg <= stack_q.node;
                    top_cur_reg  <= stack_q.cursor;
                    depth_reg    <= depth_reg - DEPTH_W'(1);
                    state_reg    <= S_STEP;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg       <= '{visited_node: pend_reg, last: 1'b1,
                                              edges_dropped: dropped_reg};
                        depth_reg        <= '0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
